### src/dtmf_command_prefix_matcher_defines.svh
// ----------------------------------------------------------------------------
// DTMF command prefix matcher assertion macros
// Shared property shapes for the matcher checks, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef DTMF_COMMAND_PREFIX_MATCHER_DEFINES_SVH
`define DTMF_COMMAND_PREFIX_MATCHER_DEFINES_SVH

// Same-cycle implication.
`define DCPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dcpm_pkg.sv
// ----------------------------------------------------------------------------
// DTMF command prefix matcher package
// Item types, function and status codes, defaults and cell control types.
// ----------------------------------------------------------------------------
package dcpm_pkg;

  localparam int TableSlotsDef   = 16;
  localparam int MaxKeyDigitsDef = 8;

  localparam logic [1:0] FUNC_QUERY  = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  localparam logic [2:0] STAT_NO_MATCH = 3'd0;
  localparam logic [2:0] STAT_MATCHED  = 3'd1;
  localparam logic [2:0] STAT_DONE     = 3'd2;
  localparam logic [2:0] STAT_DUP      = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  digit;
    logic        last;
    logic [31:0] key;
    logic [3:0]  key_length;
    logic        exact;
    logic [7:0]  handler;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] matched_handler;
    logic [3:0] arg_start;
    logic [3:0] slot;
  } out_item_t;

  typedef struct packed {
    logic digit_en;
    logic last;
    logic load;
    logic wr_en;
    logic clr_en;
    logic sm_init;
  } cell_ctrl_t;

  typedef struct packed {
    logic best;
    logic found;
    logic vacant;
  } acc_flags_t;

endpackage

### src/dcpm_cell.sv
// ----------------------------------------------------------------------------
// DTMF command prefix matcher table cell
// Holds one table slot, tracks its prefix agreement with the query, and
// folds its candidacy into the selection passed along the cell chain.
// ----------------------------------------------------------------------------
module dcpm_cell #(
  parameter int TABLE_SLOTS    = dcpm_pkg::TableSlotsDef,
  parameter int MAX_KEY_DIGITS = dcpm_pkg::MaxKeyDigitsDef,
  parameter int CELL_IDX       = 0,
  localparam int SlotW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
  localparam int LenW   = $clog2(MAX_KEY_DIGITS + 1),
  localparam int KeyW   = 4 * MAX_KEY_DIGITS,
  localparam int DigIdxW = (MAX_KEY_DIGITS > 1) ? $clog2(MAX_KEY_DIGITS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dcpm_pkg::cell_ctrl_t   ctrl_i,
  input  logic [3:0]             digit_i,
  input  logic [5:0]             pos_i,
  input  logic [5:0]             qlen_i,
  input  logic [KeyW-1:0]        key_i,
  input  logic [LenW-1:0]        len_i,
  input  logic                   exact_i,
  input  logic [7:0]             handler_i,
  input  dcpm_pkg::acc_flags_t   flags_i,
  input  logic [LenW-1:0]        best_len_i,
  input  logic [SlotW-1:0]       best_slot_i,
  input  logic [7:0]             best_handler_i,
  input  logic [SlotW-1:0]       found_slot_i,
  input  logic [SlotW-1:0]       vacant_slot_i,
  output dcpm_pkg::acc_flags_t   flags_o,
  output logic [LenW-1:0]        best_len_o,
  output logic [SlotW-1:0]       best_slot_o,
  output logic [7:0]             best_handler_o,
  output logic [SlotW-1:0]       found_slot_o,
  output logic [SlotW-1:0]       vacant_slot_o
);

  logic                           valid_q;
  logic                           sm_q;
  logic                           cand_q;
  logic                           hit_q;
  logic [MAX_KEY_DIGITS-1:0][3:0] key_q;
  logic [LenW-1:0]                len_q;
  logic                           exact_q;
  logic [7:0]                     handler_q;

  logic [3:0]           nib;
  logic                 mismatch;
  logic                 sm_new;
  logic                 cand_d;
  logic                 hit_d;
  dcpm_pkg::acc_flags_t flags_d;
  logic [LenW-1:0]      best_len_d;
  logic [SlotW-1:0]     best_slot_d;
  logic [7:0]           best_handler_d;
  logic [SlotW-1:0]     found_slot_d;
  logic [SlotW-1:0]     vacant_slot_d;

  always_comb begin
    nib      = key_q[pos_i[DigIdxW-1:0]];
    mismatch = (pos_i < 6'(len_q)) && (nib != digit_i);
    sm_new   = sm_q && !mismatch;
    cand_d   = valid_q && sm_new && (len_q != '0) && (6'(len_q) <= qlen_i) &&
               !(exact_q && (6'(len_q) != qlen_i));
    hit_d    = valid_q && (len_q == len_i) && (key_q == key_i);
  end

  always_comb begin
    flags_d        = flags_i;
    best_len_d     = best_len_i;
    best_slot_d    = best_slot_i;
    best_handler_d = best_handler_i;
    found_slot_d   = found_slot_i;
    vacant_slot_d  = vacant_slot_i;
    if (cand_q && (!flags_i.best || (len_q > best_len_i))) begin
      flags_d.best   = 1'b1;
      best_len_d     = len_q;
      best_slot_d    = SlotW'(CELL_IDX);
      best_handler_d = handler_q;
    end
    if (!flags_i.found && hit_q) begin
      flags_d.found = 1'b1;
      found_slot_d  = SlotW'(CELL_IDX);
    end
    if (!flags_i.vacant && !valid_q) begin
      flags_d.vacant = 1'b1;
      vacant_slot_d  = SlotW'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sm_q    <= 1'b1;
      cand_q  <= 1'b0;
      hit_q   <= 1'b0;
      flags_o <= '0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q <= 1'b1;
        sm_q    <= ctrl_i.sm_init;
      end else if (ctrl_i.clr_en) begin
        valid_q <= 1'b0;
      end else if (ctrl_i.digit_en) begin
        sm_q <= ctrl_i.last ? 1'b1 : sm_new;
      end
      if (ctrl_i.load) begin
        cand_q <= cand_d;
        hit_q  <= hit_d;
      end
      flags_o <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      key_q     <= key_i;
      len_q     <= len_i;
      exact_q   <= exact_i;
      handler_q <= handler_i;
    end
    best_len_o     <= best_len_d;
    best_slot_o    <= best_slot_d;
    best_handler_o <= best_handler_d;
    found_slot_o   <= found_slot_d;
    vacant_slot_o  <= vacant_slot_d;
  end

endmodule

### src/dtmf_command_prefix_matcher.sv
// ----------------------------------------------------------------------------
// DTMF command prefix matcher
// Command key table with streaming longest-prefix lookup of tone digits.
// ----------------------------------------------------------------------------
// A query digit that is not the last one, and a transfer with the unused
// function code, is taken without a stall and gives no result. A last query
// digit, an add and a remove present their result once the slot selection
// (longest match, first duplicate, first free slot) has travelled through
// the chain of table cells one cell per cycle, and the input stalls until
// the result register loads, so the next item is taken only after that. A
// finished result may wait in the output register while the next item is
// taken; the next result loads only once the waiting one has left.
`include "dtmf_command_prefix_matcher_defines.svh"

module dtmf_command_prefix_matcher #(
  parameter int TABLE_SLOTS    = dcpm_pkg::TableSlotsDef,
  parameter int MAX_KEY_DIGITS = dcpm_pkg::MaxKeyDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dcpm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dcpm_pkg::out_item_t out_data_o
);

  localparam int SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int LenW  = $clog2(MAX_KEY_DIGITS + 1);
  localparam int KeyW  = 4 * MAX_KEY_DIGITS;
  localparam int CntW  = $clog2(TABLE_SLOTS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [5:0]          qcount_q, qcount_d;
  logic                out_valid_q, out_valid_d;
  dcpm_pkg::out_item_t out_data_q, res;

  logic [1:0]      op_func_q;
  logic [KeyW-1:0] op_key_q;
  logic [LenW-1:0] op_len_q;
  logic            op_exact_q;
  logic [7:0]      op_handler_q;

  logic                 in_acc;
  logic                 start;
  logic                 digit_en;
  logic                 res_load;
  logic                 add_ok;
  logic                 rm_ok;
  logic [4:0]           len_ext;
  logic [LenW-1:0]      in_len;
  logic [KeyW+31:0]     key_wide;
  logic [KeyW-1:0]      in_key_m;
  logic [KeyW-1:0]      bus_key;
  logic [LenW-1:0]      bus_len;
  logic [5:0]           qlen;
  logic [TABLE_SLOTS-1:0] wr_sel;
  logic [TABLE_SLOTS-1:0] clr_sel;

  dcpm_pkg::cell_ctrl_t cell_ctrl    [TABLE_SLOTS];
  dcpm_pkg::acc_flags_t chain_flags  [TABLE_SLOTS+1];
  logic [LenW-1:0]      chain_len    [TABLE_SLOTS+1];
  logic [SlotW-1:0]     chain_slot   [TABLE_SLOTS+1];
  logic [7:0]           chain_hdl    [TABLE_SLOTS+1];
  logic [SlotW-1:0]     chain_found  [TABLE_SLOTS+1];
  logic [SlotW-1:0]     chain_vacant [TABLE_SLOTS+1];

  assign in_stall_o  = (state_q == ST_SCAN);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign digit_en = in_acc && (in_data_i.func == dcpm_pkg::FUNC_QUERY);
  assign start    = in_acc && (((in_data_i.func == dcpm_pkg::FUNC_QUERY) && in_data_i.last) ||
                               (in_data_i.func == dcpm_pkg::FUNC_ADD) ||
                               (in_data_i.func == dcpm_pkg::FUNC_REMOVE));

  always_comb begin
    len_ext  = {1'b0, in_data_i.key_length};
    in_len   = (len_ext > 5'(MAX_KEY_DIGITS)) ? LenW'(MAX_KEY_DIGITS) : LenW'(len_ext);
    key_wide = {{KeyW{1'b0}}, in_data_i.key};
    for (int b = 0; b < KeyW; b++) begin
      in_key_m[b] = key_wide[b] && ((b >> 2) < int'(in_len));
    end
  end

  assign bus_key = in_stall_o ? op_key_q : in_key_m;
  assign bus_len = in_stall_o ? op_len_q : in_len;
  assign qlen    = (qcount_q == 6'd63) ? 6'd63 : qcount_q + 6'd1;

  assign chain_flags[0]  = '0;
  assign chain_len[0]    = '0;
  assign chain_slot[0]   = '0;
  assign chain_hdl[0]    = '0;
  assign chain_found[0]  = '0;
  assign chain_vacant[0] = '0;

  assign add_ok = (op_func_q == dcpm_pkg::FUNC_ADD) && (op_len_q != '0) &&
                  !chain_flags[TABLE_SLOTS].found && chain_flags[TABLE_SLOTS].vacant;
  assign rm_ok  = (op_func_q == dcpm_pkg::FUNC_REMOVE) && (op_len_q != '0) &&
                  chain_flags[TABLE_SLOTS].found;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    assign wr_sel[i]  = res_load && add_ok && (chain_vacant[TABLE_SLOTS] == SlotW'(i));
    assign clr_sel[i] = res_load && rm_ok && (chain_found[TABLE_SLOTS] == SlotW'(i));

    always_comb begin
      cell_ctrl[i].digit_en = digit_en;
      cell_ctrl[i].last     = in_data_i.last;
      cell_ctrl[i].load     = start;
      cell_ctrl[i].wr_en    = wr_sel[i];
      cell_ctrl[i].clr_en   = clr_sel[i];
      cell_ctrl[i].sm_init  = (qcount_q == 6'd0);
    end

    dcpm_cell #(
      .TABLE_SLOTS    (TABLE_SLOTS),
      .MAX_KEY_DIGITS (MAX_KEY_DIGITS),
      .CELL_IDX       (i)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (cell_ctrl[i]),
      .digit_i        (in_data_i.digit),
      .pos_i          (qcount_q),
      .qlen_i         (qlen),
      .key_i          (bus_key),
      .len_i          (bus_len),
      .exact_i        (op_exact_q),
      .handler_i      (op_handler_q),
      .flags_i        (chain_flags[i]),
      .best_len_i     (chain_len[i]),
      .best_slot_i    (chain_slot[i]),
      .best_handler_i (chain_hdl[i]),
      .found_slot_i   (chain_found[i]),
      .vacant_slot_i  (chain_vacant[i]),
      .flags_o        (chain_flags[i+1]),
      .best_len_o     (chain_len[i+1]),
      .best_slot_o    (chain_slot[i+1]),
      .best_handler_o (chain_hdl[i+1]),
      .found_slot_o   (chain_found[i+1]),
      .vacant_slot_o  (chain_vacant[i+1])
    );
  end

  always_comb begin
    res = '0;
    unique case (op_func_q)
      dcpm_pkg::FUNC_ADD: begin
        if (op_len_q == '0) begin
          res.status = dcpm_pkg::STAT_DUP;
        end else if (chain_flags[TABLE_SLOTS].found) begin
          res.status = dcpm_pkg::STAT_DUP;
          res.slot   = 4'(chain_found[TABLE_SLOTS]);
        end else if (!chain_flags[TABLE_SLOTS].vacant) begin
          res.status = dcpm_pkg::STAT_FULL;
        end else begin
          res.status = dcpm_pkg::STAT_DONE;
          res.slot   = 4'(chain_vacant[TABLE_SLOTS]);
        end
      end
      dcpm_pkg::FUNC_REMOVE: begin
        if (rm_ok) begin
          res.status = dcpm_pkg::STAT_DONE;
          res.slot   = 4'(chain_found[TABLE_SLOTS]);
        end else begin
          res.status = dcpm_pkg::STAT_DUP;
        end
      end
      default: begin
        if (chain_flags[TABLE_SLOTS].best) begin
          res.status          = dcpm_pkg::STAT_MATCHED;
          res.matched_handler = chain_hdl[TABLE_SLOTS];
          res.arg_start       = 4'(chain_len[TABLE_SLOTS]);
          res.slot            = 4'(chain_slot[TABLE_SLOTS]);
        end else begin
          res.status = dcpm_pkg::STAT_NO_MATCH;
        end
      end
    endcase
  end

  assign res_load = (state_q == ST_SCAN) && (cnt_q == CntW'(TABLE_SLOTS)) &&
                    (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    qcount_d    = qcount_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_q != CntW'(TABLE_SLOTS)) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (res_load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (digit_en) begin
      if (in_data_i.last) begin
        qcount_d = 6'd0;
      end else if (qcount_q != 6'd63) begin
        qcount_d = qcount_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      qcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      qcount_q    <= qcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      op_func_q    <= in_data_i.func;
      op_key_q     <= in_key_m;
      op_len_q     <= in_len;
      op_exact_q   <= in_data_i.exact;
      op_handler_q <= in_data_i.handler;
    end
    if (res_load) begin
      out_data_q <= res;
    end
  end

  `DCPM_ASSERT_NOW(a_single_slot_write, 1'b1, $onehot0(wr_sel | clr_sel), "two slots written at once")
  `DCPM_ASSERT_NOW(a_load_after_full_pass, res_load, cnt_q == CntW'(TABLE_SLOTS), "result before chain settled")
  `DCPM_ASSERT_NEXT(a_query_count_clear, digit_en && in_data_i.last, qcount_q == 6'd0, "query length not cleared")
  `DCPM_ASSERT_NEXT(a_result_presented, res_load, out_valid_q && (state_q == ST_IDLE), "result not presented")

endmodule

### test/tb_dtmf_command_prefix_matcher.sv
// ----------------------------------------------------------------------------
// DTMF command prefix matcher testbench
// Drives add, remove, query-digit and unused-function transfers with random
// input idle and output stall. A scoreboard keeps its own copy of the command
// table, predicts each reply and checks replies in order, field by field.
// ----------------------------------------------------------------------------
module tb_dtmf_command_prefix_matcher;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int QueryCountMax = 63;

  class prefix_match_scoreboard;
    bit          used_q[dcpm_pkg::TableSlotsDef];
    logic [31:0] key_q[dcpm_pkg::TableSlotsDef];
    logic [3:0]  len_q[dcpm_pkg::TableSlotsDef];
    bit          exact_q[dcpm_pkg::TableSlotsDef];
    logic [7:0]  tag_q[dcpm_pkg::TableSlotsDef];
    bit          agree_q[dcpm_pkg::TableSlotsDef];
    int unsigned digits_seen;
    dcpm_pkg::out_item_t replies_due[$];
    int unsigned errors;

    function new();
      int i;
      for (i = 0; i < dcpm_pkg::TableSlotsDef; i++) begin
        used_q[i] = 1'b0;
        key_q[i] = '0;
        len_q[i] = '0;
        exact_q[i] = 1'b0;
        tag_q[i] = '0;
        agree_q[i] = 1'b1;
      end
      digits_seen = 0;
      errors = 0;
    endfunction

    static function logic [31:0] digit_mask(int unsigned n);
      if (n >= 8) return '1;
      return (32'd1 << (4 * n)) - 32'd1;
    endfunction

    function void push_reply(logic [2:0] st, logic [7:0] tag, logic [3:0] arg,
                             logic [3:0] slot);
      dcpm_pkg::out_item_t r;
      r.status = st;
      r.matched_handler = tag;
      r.arg_start = arg;
      r.slot = slot;
      replies_due.push_back(r);
    endfunction

    function void predict_transfer(dcpm_pkg::in_item_t it);
      int unsigned pos, qlen, klen, best_len;
      int best, found, vacant, i;
      logic [31:0] k;
      pos = digits_seen;
      best = -1;
      best_len = 0;
      found = -1;
      vacant = -1;
      klen = (it.key_length > dcpm_pkg::MaxKeyDigitsDef) ?
             dcpm_pkg::MaxKeyDigitsDef : it.key_length;
      k = it.key & digit_mask(klen);
      case (it.func)
        dcpm_pkg::FUNC_QUERY: begin
          for (i = 0; i < dcpm_pkg::TableSlotsDef; i++) begin
            if (pos < len_q[i] && 4'(key_q[i] >> (4 * pos)) != it.digit)
              agree_q[i] = 1'b0;
          end
          if (!it.last) begin
            if (digits_seen < QueryCountMax) digits_seen++;
            return;
          end
          qlen = (pos + 1 > QueryCountMax) ? QueryCountMax : pos + 1;
          for (i = 0; i < dcpm_pkg::TableSlotsDef; i++) begin
            if (!used_q[i] || !agree_q[i] || len_q[i] == 0 || len_q[i] > qlen) continue;
            if (exact_q[i] && len_q[i] != qlen) continue;
            if (best < 0 || len_q[i] > best_len) begin
              best = i;
              best_len = len_q[i];
            end
          end
          for (i = 0; i < dcpm_pkg::TableSlotsDef; i++) agree_q[i] = 1'b1;
          digits_seen = 0;
          if (best < 0) push_reply(dcpm_pkg::STAT_NO_MATCH, '0, '0, '0);
          else push_reply(dcpm_pkg::STAT_MATCHED, tag_q[best], 4'(best_len), 4'(best));
        end
        dcpm_pkg::FUNC_ADD, dcpm_pkg::FUNC_REMOVE: begin
          if (klen == 0) begin
            push_reply(dcpm_pkg::STAT_DUP, '0, '0, '0);
            return;
          end
          for (i = 0; i < dcpm_pkg::TableSlotsDef; i++) begin
            if (found < 0 && used_q[i] && len_q[i] == klen && key_q[i] == k) found = i;
          end
          if (it.func == dcpm_pkg::FUNC_ADD) begin
            if (found >= 0) begin
              push_reply(dcpm_pkg::STAT_DUP, '0, '0, 4'(found));
            end else begin
              for (i = 0; i < dcpm_pkg::TableSlotsDef; i++) begin
                if (vacant < 0 && !used_q[i]) vacant = i;
              end
              if (vacant < 0) begin
                push_reply(dcpm_pkg::STAT_FULL, '0, '0, '0);
              end else begin
                used_q[vacant] = 1'b1;
                key_q[vacant] = k;
                len_q[vacant] = 4'(klen);
                exact_q[vacant] = it.exact;
                tag_q[vacant] = it.handler;
                agree_q[vacant] = (digits_seen == 0);
                push_reply(dcpm_pkg::STAT_DONE, '0, '0, 4'(vacant));
              end
            end
          end else if (found < 0) begin
            push_reply(dcpm_pkg::STAT_DUP, '0, '0, '0);
          end else begin
            used_q[found] = 1'b0;
            push_reply(dcpm_pkg::STAT_DONE, '0, '0, 4'(found));
          end
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(dcpm_pkg::out_item_t got);
      dcpm_pkg::out_item_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply, expected none actual %h", $time, got);
        return;
      end
      want = replies_due.pop_front();
      check_field("status", 8'(want.status), 8'(got.status));
      check_field("matched_handler", want.matched_handler, got.matched_handler);
      check_field("arg_start", 8'(want.arg_start), 8'(got.arg_start));
      check_field("slot", 8'(want.slot), 8'(got.slot));
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  dcpm_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  dcpm_pkg::out_item_t out_data_o;

  prefix_match_scoreboard sb = new();
  logic [31:0] family_key[4];
  logic [3:0]  query_digits[$];
  int unsigned send_idle_pct = 27;
  int unsigned recv_stall_pct = 61;
  int unsigned items_sent = 0;

  dtmf_command_prefix_matcher u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_reply(out_data_o);
  end

  function automatic dcpm_pkg::in_item_t random_item(logic [1:0] f);
    dcpm_pkg::in_item_t it;
    it.func = f;
    it.digit = 4'($urandom_range(15));
    it.last = 1'($urandom_range(1));
    it.key = $urandom;
    it.key_length = 4'($urandom_range(15));
    it.exact = 1'($urandom_range(1));
    it.handler = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic send(dcpm_pkg::in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.predict_transfer(it);
    if (it.func != FUNC_SPARE) items_sent++;
  endtask

  task automatic send_key_op(logic [1:0] f, logic [31:0] key, logic [3:0] len,
                             logic exact, logic [7:0] tag);
    dcpm_pkg::in_item_t it;
    it = random_item(f);
    it.key = key;
    it.key_length = len;
    it.exact = exact;
    it.handler = tag;
    send(it);
  endtask

  task automatic send_digit(logic [3:0] d, logic last);
    dcpm_pkg::in_item_t it;
    it = random_item(dcpm_pkg::FUNC_QUERY);
    it.digit = d;
    it.last = last;
    send(it);
  endtask

  task automatic send_query();
    int i;
    for (i = 0; i < query_digits.size(); i++) begin
      send_digit(query_digits[i], i == query_digits.size() - 1);
    end
  endtask

  task automatic build_query(int unsigned f, int unsigned n);
    int unsigned i;
    query_digits.delete();
    for (i = 0; i < n; i++) begin
      query_digits.push_back(i < 8 ? 4'(family_key[f] >> (4 * i)) : 4'($urandom_range(15)));
    end
  endtask

  task automatic send_random_key_op(logic [1:0] f);
    int unsigned fam, len;
    logic [31:0] m;
    logic [3:0] klen;
    fam = $urandom_range(3);
    len = $urandom_range(1, 8);
    m = prefix_match_scoreboard::digit_mask(len);
    klen = 4'(len);
    if (len == 8 && $urandom_range(1) == 1) klen = 4'($urandom_range(9, 15));
    if ($urandom_range(99) < 3) klen = '0;
    send_key_op(f, (family_key[fam] & m) | ($urandom & ~m), klen,
                $urandom_range(3) == 0, 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned r, n;
    bit long_done;
    long_done = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    for (int f = 0; f < 4; f++) family_key[f] = $urandom;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    send_key_op(dcpm_pkg::FUNC_ADD, 32'hFFFF_FFF5, 4'd1, 1'b0, 8'hFF);
    send_key_op(dcpm_pkg::FUNC_ADD, 32'h0000_0835, 4'd3, 1'b0, 8'h00);
    send_key_op(dcpm_pkg::FUNC_ADD, 32'h1234_5635, 4'd2, 1'b1, 8'hA5);
    send_key_op(dcpm_pkg::FUNC_ADD, 32'hFEDC_BA98, 4'd15, 1'b0, 8'h5A);
    send_key_op(dcpm_pkg::FUNC_ADD, 32'hABCD_E835, 4'd3, 1'b1, 8'h77);
    send_key_op(dcpm_pkg::FUNC_ADD, 32'hFFFF_FFFF, 4'd0, 1'b1, 8'h12);
    send_key_op(dcpm_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 4'd0, 1'b0, 8'h34);
    send_key_op(dcpm_pkg::FUNC_REMOVE, 32'h0000_0077, 4'd2, 1'b0, 8'h56);
    query_digits = '{4'h5, 4'h3, 4'h8, 4'h1};
    send_query();
    query_digits = '{4'h5, 4'h3};
    send_query();
    send(random_item(FUNC_SPARE));
    query_digits = '{4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF};
    send_query();
    send_digit(4'h0, 1'b0);
    send_key_op(dcpm_pkg::FUNC_ADD, 32'h0000_0000, 4'd1, 1'b0, 8'h11);
    send_digit(4'h0, 1'b1);
    send_key_op(dcpm_pkg::FUNC_REMOVE, 32'h0000_0835, 4'd3, 1'b0, 8'h00);

    while (items_sent < 500) begin
      if (items_sent >= 334) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (items_sent >= 167) begin
        send_idle_pct = 61;
        recv_stall_pct = 27;
      end
      if (!long_done && items_sent >= 250) begin
        build_query($urandom_range(3), $urandom_range(64, 70));
        send_query();
        long_done = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 35) begin
        send_random_key_op(dcpm_pkg::FUNC_ADD);
      end else if (r < 50) begin
        send_random_key_op(dcpm_pkg::FUNC_REMOVE);
      end else if (r < 90) begin
        n = $urandom_range(1, 12);
        build_query($urandom_range(3), n);
        if ($urandom_range(4) == 0) query_digits[$urandom_range(n - 1)] = 4'($urandom_range(15));
        send_query();
      end else if (r < 95) begin
        send(random_item(dcpm_pkg::FUNC_QUERY));
      end else begin
        send(random_item(FUNC_SPARE));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3 * (dcpm_pkg::TableSlotsDef + 1)) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/dcpm_pkg.sv
src/dcpm_cell.sv
src/dtmf_command_prefix_matcher.sv
test/tb_dtmf_command_prefix_matcher.sv
